// ----- src/idhcv_pkg.sv -----
// types, status codes and the add-and-rotate helper for the datagram checksum checker
// used by every module under src; depends on nothing
`timescale 1ns / 1ps

package idhcv_pkg;

    localparam int HEADER_BYTES_DEF = 30;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_SKIPPED  = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    localparam logic [15:0] SUM_DISABLED = 16'hFFFF;
    localparam logic [15:0] INDEX_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_frame;
        logic       end_of_frame;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] computed_sum;
        logic [15:0] received_sum;
        logic [15:0] packet_length;
        logic [7:0]  packet_type;
    } t_out_beat;

    // handshake between the input register and the checksum core
    typedef struct packed {
        logic     valid;
        t_in_beat beat;
    } t_in_slot;

    // one's complement add, then rotate left by one
    function automatic logic [15:0] add_rotate(input logic [15:0] sum, input logic [15:0] word);
        logic [16:0] s17;
        logic [15:0] s1;
        s17 = {1'b0, sum} + {1'b0, word};
        s1  = s17[16] ? (s17[15:0] + 16'd1) : s17[15:0];
        return {s1[14:0], s1[15]};
    endfunction

endpackage

// ----- src/idhcv_in_stage.sv -----
// input register for the byte stream
// depends on idhcv_pkg
`timescale 1ns / 1ps

module idhcv_in_stage import idhcv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_beat i_in_data,
    input  logic     i_take,
    output t_in_slot o_slot
);

    logic     r_valid;
    t_in_beat r_beat;

    assign o_in_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_beat <= i_in_data;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.beat  = r_beat;

endmodule

// ----- src/idhcv_core.sv -----
// per-packet state and the add-and-rotate update, one byte per cycle while no verdict waits for the result register
// depends on idhcv_pkg
`timescale 1ns / 1ps

module idhcv_core import idhcv_pkg::*; #(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_slot  i_slot,
    output logic      o_take,
    input  logic      i_out_free,
    output logic      o_res_load,
    output t_out_beat o_res
);

    typedef struct packed {
        logic [15:0] byte_index;
        logic [15:0] running_sum;
        logic [7:0]  held_high_byte;
        logic [15:0] cap_sum;
        logic [15:0] cap_len;
        logic [7:0]  cap_type;
        logic        in_packet;
        logic        verdict_given;
    } t_pkt_state;

    t_pkt_state  r_st;
    t_pkt_state  n_st;
    t_pkt_state  base;
    logic [15:0] idx;
    logic [7:0]  b;
    logic        sof;
    logic        eof;
    logic        emit;
    logic        short_len;
    logic        complete;
    logic        do_add;
    logic [15:0] word;
    t_out_beat   res;

    always_comb begin
        b   = i_slot.beat.data_byte;
        sof = i_slot.beat.start_of_frame;
        eof = i_slot.beat.end_of_frame;

        base = r_st;
        if (sof) begin
            base           = '0;
            base.in_packet = 1'b1;
        end

        idx       = base.byte_index;
        n_st      = base;
        emit      = 1'b0;
        short_len = 1'b0;
        complete  = 1'b0;
        do_add    = 1'b0;
        word      = '0;
        res       = '0;

        if (base.in_packet) begin
            if (base.verdict_given) begin
                if (eof) begin
                    n_st.in_packet = 1'b0;
                end
            end else begin
                case (idx)
                    16'd0: n_st.cap_sum      = {b, 8'h00};
                    16'd1: n_st.cap_sum[7:0] = b;
                    16'd2: n_st.cap_len      = {b, 8'h00};
                    16'd3: n_st.cap_len[7:0] = b;
                    16'd5: n_st.cap_type     = b;
                    default: ;
                endcase

                short_len = (idx == 16'd3) && (n_st.cap_len < 16'(HEADER_BYTES));
                complete  = (idx >= 16'd3) &&
                            (({1'b0, idx} + 17'd1) == {1'b0, n_st.cap_len});

                if (idx >= 16'd2) begin
                    if (idx[0]) begin
                        do_add = 1'b1;
                        word   = {base.held_high_byte, b};
                    end else begin
                        n_st.held_high_byte = b;
                        // odd length: pad the last byte with a zero low byte
                        if (complete && !short_len) begin
                            do_add = 1'b1;
                            word   = {b, 8'h00};
                        end
                    end
                end
                if (do_add) begin
                    n_st.running_sum = add_rotate(base.running_sum, word);
                end

                res.received_sum  = n_st.cap_sum;
                res.packet_length = n_st.cap_len;
                res.packet_type   = n_st.cap_type;
                res.computed_sum  = n_st.running_sum;

                if (short_len) begin
                    emit             = 1'b1;
                    res.status       = ST_SHORT;
                    res.computed_sum = '0;
                end else if (complete) begin
                    emit = 1'b1;
                    if (n_st.cap_sum == SUM_DISABLED) begin
                        res.status = ST_SKIPPED;
                    end else if (n_st.cap_sum == n_st.running_sum) begin
                        res.status = ST_OK;
                    end else begin
                        res.status = ST_MISMATCH;
                    end
                end else if (eof) begin
                    emit       = 1'b1;
                    res.status = ST_TRUNC;
                end

                if (emit) begin
                    n_st.verdict_given = 1'b1;
                end
                if (idx != INDEX_MAX) begin
                    n_st.byte_index = idx + 16'd1;
                end
                if (eof) begin
                    n_st.in_packet = 1'b0;
                end
            end
        end
    end

    // a beat that yields a verdict waits until the result register can take it
    assign o_take     = i_slot.valid && (!emit || i_out_free);
    assign o_res_load = o_take && emit;
    assign o_res      = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (o_take) begin
            r_st <= n_st;
        end
    end

`ifndef SYNTHESIS
    a_verdict_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |=> r_st.verdict_given)
        else $error("verdict given but packet not marked");

    a_sof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_slot.beat.start_of_frame |=> r_st.byte_index == 16'd1)
        else $error("start of frame did not restart the byte count");

    a_short_at_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load && o_res.status == ST_SHORT |-> idx == 16'd3 && o_res.computed_sum == 16'd0)
        else $error("length short verdict away from the length field");

    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> !base.verdict_given)
        else $error("second verdict within one packet");
`endif

endmodule

// ----- src/idhcv_out_stage.sv -----
// result register that holds a verdict until the consumer takes it
// depends on idhcv_pkg
`timescale 1ns / 1ps

module idhcv_out_stage import idhcv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_beat i_res,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    logic      r_valid;
    t_out_beat r_res;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_res;

endmodule

// ----- src/idp_header_checksum_verify_top.sv -----
// datagram checksum checker: byte stream in, at most one verdict beat per packet out
// a beat goes through the input register, the core, then the result register
// throughput: one byte beat per cycle; the add-and-rotate update is one step per word
// a beat that yields a verdict stalls only while the result register is still full
// reset: synchronous active-low i_rst_n clears packet state and both valid flags
// depends on idhcv_pkg, idhcv_in_stage, idhcv_core, idhcv_out_stage
`timescale 1ns / 1ps

module idp_header_checksum_verify_top import idhcv_pkg::*; #(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_in_slot  slot;
    logic      take;
    logic      out_free;
    logic      res_load;
    t_out_beat res;

    idhcv_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_take     (take),
        .o_slot     (slot)
    );

    idhcv_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot     (slot),
        .o_take     (take),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    idhcv_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_load),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- test/tb.sv -----
// self-checking testbench for idp_header_checksum_verify_top: byte frames in, verdict beats out
// predicts each verdict from its own model of the add-and-rotate checksum; depends on idhcv_pkg
`timescale 1ns / 1ps

module tb;
    import idhcv_pkg::*;

    localparam int MIN_LEN      = HEADER_BYTES_DEF;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 500;
    localparam int RANDOM_BEATS = 600;

    typedef enum int {SUM_GOOD, SUM_BAD, SUM_OFF} t_sum_kind;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill_kind;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    idp_header_checksum_verify_top #(.HEADER_BYTES(MIN_LEN)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // checker model of the datagram state
    logic [15:0] frame_pos;
    logic [15:0] run_sum;
    logic [7:0]  hi_byte;
    logic [15:0] got_csum;
    logic [15:0] got_len;
    logic [7:0]  got_type;
    logic        frame_open;
    logic        verdict_done;

    t_out_beat pending_verdicts[$];
    logic [7:0] frame[$];

    int  beats_in;
    int  verdicts_seen;
    int  mismatches;
    int  stalled;
    int  n_ok, n_bad, n_off, n_short, n_trunc;
    bit  idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sum plus word with end-around carry, then rotate left by one
    function automatic logic [15:0] fold_rotate(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        if (s[16]) s = {1'b0, s[15:0] + 16'd1};
        s = {s[15:0], 1'b0};
        if (s[16]) s = {1'b0, s[15:0] + 16'd1};
        return s[15:0];
    endfunction

    function automatic void push_verdict(input logic [2:0] status, input logic [15:0] sum);
        t_out_beat v;
        v.status        = status;
        v.computed_sum  = sum;
        v.received_sum  = got_csum;
        v.packet_length = got_len;
        v.packet_type   = got_type;
        pending_verdicts.push_back(v);
        verdict_done = 1'b1;
    endfunction

    function automatic void predict_beat(input t_in_beat b);
        int idx;
        if (b.start_of_frame) begin
            frame_pos    = '0;
            run_sum      = '0;
            hi_byte      = '0;
            got_csum     = '0;
            got_len      = '0;
            got_type     = '0;
            frame_open   = 1'b1;
            verdict_done = 1'b0;
        end
        if (!frame_open) return;
        if (verdict_done) begin
            if (b.end_of_frame) frame_open = 1'b0;
            return;
        end
        idx = int'(frame_pos);
        case (idx)
            0: got_csum = {b.data_byte, 8'h00};
            1: got_csum[7:0] = b.data_byte;
            2: got_len = {b.data_byte, 8'h00};
            3: got_len[7:0] = b.data_byte;
            5: got_type = b.data_byte;
            default: ;
        endcase
        if (idx >= 2) begin
            if (idx % 2 == 0) hi_byte = b.data_byte;
            else run_sum = fold_rotate(run_sum, {hi_byte, b.data_byte});
        end
        if (idx == 3 && int'(got_len) < MIN_LEN) begin
            push_verdict(ST_SHORT, 16'h0000);
        end else if (idx >= 3 && idx + 1 == int'(got_len)) begin
            // odd length: last byte padded with a zero low byte
            if (idx % 2 == 0) run_sum = fold_rotate(run_sum, {hi_byte, 8'h00});
            if (got_csum == SUM_DISABLED) push_verdict(ST_SKIPPED, run_sum);
            else push_verdict(got_csum == run_sum ? ST_OK : ST_MISMATCH, run_sum);
        end else if (b.end_of_frame) begin
            push_verdict(ST_TRUNC, run_sum);
        end
        if (frame_pos != INDEX_MAX) frame_pos = frame_pos + 16'd1;
        if (b.end_of_frame) frame_open = 1'b0;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // sample both channels at the rising edge; watchdog on cycles without progress
    always @(posedge i_clk) begin
        t_out_beat want;
        bit progress;
        progress = 1'b0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            progress = 1'b1;
            verdicts_seen++;
            case (o_out_data.status)
                ST_OK:       n_ok++;
                ST_MISMATCH: n_bad++;
                ST_SKIPPED:  n_off++;
                ST_SHORT:    n_short++;
                ST_TRUNC:    n_trunc++;
                default: ;
            endcase
            if (pending_verdicts.size() == 0) begin
                $error("verdict beat with none pending: status %0d", o_out_data.status);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("status", 32'(want.status), 32'(o_out_data.status));
                check_field("computed_sum", 32'(want.computed_sum),
                            32'(o_out_data.computed_sum));
                check_field("received_sum", 32'(want.received_sum),
                            32'(o_out_data.received_sum));
                check_field("packet_length", 32'(want.packet_length),
                            32'(o_out_data.packet_length));
                check_field("packet_type", 32'(want.packet_type),
                            32'(o_out_data.packet_type));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            progress = 1'b1;
            beats_in++;
            predict_beat(i_in_data);
        end
        stalled = progress ? 0 : stalled + 1;
        if (stalled == STALL_LIMIT) begin
            $display("idp_header_checksum_verify_top verification failed");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) hold--;
            else if (idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 7);
            i_out_ready <= (hold == 0);
        end
    end

    task automatic send_beat(input logic [7:0] d, input logic sof, input logic eof);
        t_in_beat b;
        int seen;
        b.data_byte      = d;
        b.start_of_frame = sof;
        b.end_of_frame   = eof;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        seen = beats_in;
        do @(negedge i_clk); while (beats_in == seen);
    endtask

    // len_field goes in bytes 2-3; total is how many bytes the link delivers
    task automatic build_frame(input int len_field, input int total, input t_sum_kind sum_kind,
                               input t_fill_kind fill);
        logic [15:0] acc;
        logic [15:0] csum;
        frame.delete();
        for (int i = 0; i < total; i++) begin
            case (fill)
                FILL_ZERO: frame.push_back(8'h00);
                FILL_ONES: frame.push_back(8'hFF);
                default:   frame.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (total > 2) frame[2] = 8'(len_field >> 8);
        if (total > 3) frame[3] = 8'(len_field);
        acc = 16'($urandom_range(0, 16'hFFFF));
        if (len_field >= MIN_LEN && total >= len_field) begin
            acc = '0;
            for (int i = 2; i + 1 < len_field; i += 2)
                acc = fold_rotate(acc, {frame[i], frame[i + 1]});
            if (len_field % 2 == 1) acc = fold_rotate(acc, {frame[len_field - 1], 8'h00});
        end
        case (sum_kind)
            SUM_GOOD: csum = acc;
            SUM_BAD:  csum = acc ^ 16'($urandom_range(1, 16'hFFFF));
            default:  csum = SUM_DISABLED;
        endcase
        if (total > 0) frame[0] = csum[15:8];
        if (total > 1) frame[1] = csum[7:0];
    endtask

    task automatic send_frame(input bit close);
        for (int i = 0; i < frame.size(); i++)
            send_beat(frame[i], i == 0, close && i == frame.size() - 1);
    endtask

    task automatic test_stray_bytes();
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hA5, 1'b0, 1'b0);
    endtask

    task automatic test_short_length();
        build_frame(0, 4, SUM_GOOD, FILL_ZERO);
        send_frame(1'b1);
        build_frame(MIN_LEN - 1, 7, SUM_BAD, FILL_ONES);
        send_frame(1'b0);
        // end of frame on the byte that completes a short length
        build_frame(MIN_LEN - 1, 4, SUM_OFF, FILL_RANDOM);
        send_frame(1'b1);
    endtask

    task automatic test_good_frames();
        build_frame(MIN_LEN, MIN_LEN, SUM_GOOD, FILL_ZERO);
        send_frame(1'b1);
        build_frame(MIN_LEN + 1, MIN_LEN + 1, SUM_GOOD, FILL_ONES);
        send_frame(1'b1);
        // bytes past the length are dropped
        build_frame(64, 67, SUM_GOOD, FILL_RANDOM);
        send_frame(1'b1);
    endtask

    task automatic test_bad_and_skipped();
        build_frame(MIN_LEN + 3, MIN_LEN + 3, SUM_BAD, FILL_RANDOM);
        send_frame(1'b1);
        build_frame(MIN_LEN + 2, MIN_LEN + 2, SUM_OFF, FILL_RANDOM);
        send_frame(1'b1);
    endtask

    task automatic test_truncation();
        build_frame(MIN_LEN, 1, SUM_GOOD, FILL_ONES);
        send_frame(1'b1);
        build_frame(MIN_LEN, 2, SUM_BAD, FILL_RANDOM);
        send_frame(1'b1);
        build_frame(40, 4, SUM_GOOD, FILL_RANDOM);
        send_frame(1'b1);
        build_frame(50, 17, SUM_GOOD, FILL_RANDOM);
        send_frame(1'b1);
    endtask

    task automatic test_restart();
        build_frame(40, 20, SUM_GOOD, FILL_RANDOM);
        send_frame(1'b0);
        build_frame(MIN_LEN, MIN_LEN, SUM_GOOD, FILL_RANDOM);
        send_frame(1'b1);
    endtask

    // largest length field, cut short by the link
    task automatic test_max_length();
        build_frame(16'hFFFF, 48, SUM_GOOD, FILL_RANDOM);
        send_frame(1'b1);
    endtask

    task automatic test_random_traffic();
        int first_beat, roll, len, total;
        t_fill_kind fill;
        first_beat = beats_in;
        while (beats_in - first_beat < RANDOM_BEATS) begin
            // last stretch runs at full rate on both sides
            idle_on = (beats_in - first_beat < RANDOM_BEATS - 150) && ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 15);
            fill = roll == 0 ? FILL_ZERO : roll == 1 ? FILL_ONES : FILL_RANDOM;
            roll = $urandom_range(0, 99);
            len  = $urandom_range(MIN_LEN, 64);
            if (roll < 60) begin
                total = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
                build_frame(len, total, roll < 45 ? SUM_GOOD : SUM_BAD, fill);
                send_frame($urandom_range(0, 7) != 0);
            end else if (roll < 65) begin
                build_frame(len, len, SUM_OFF, fill);
                send_frame(1'b1);
            end else if (roll < 75) begin
                build_frame($urandom_range(0, MIN_LEN - 1), $urandom_range(4, 8), SUM_GOOD, fill);
                send_frame(1'($urandom_range(0, 1)));
            end else if (roll < 85) begin
                if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 16'hFFFF);
                build_frame(len, $urandom_range(1, 40 < len - 1 ? 40 : (len > 1 ? len - 1 : 1)),
                            SUM_GOOD, fill);
                send_frame(1'b1);
            end else if (roll < 92) begin
                build_frame(len, $urandom_range(1, len - 1), SUM_GOOD, fill);
                send_frame(1'b0);
            end else begin
                repeat ($urandom_range(1, 12))
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
            end
        end
        idle_on = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b1;
        idle_on     = 1'b1;
        frame_pos   = '0;
        run_sum     = '0;
        hi_byte     = '0;
        got_csum    = '0;
        got_len     = '0;
        got_type    = '0;
        frame_open  = 1'b0;
        verdict_done = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_stray_bytes();
        test_short_length();
        test_good_frames();
        test_bad_and_skipped();
        test_truncation();
        test_restart();
        test_max_length();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d byte beats and %0d verdicts", beats_in, verdicts_seen);
        $display("ok %0d, mismatch %0d, not checked %0d, short %0d, truncated %0d",
                 n_ok, n_bad, n_off, n_short, n_trunc);
        if (mismatches == 0) begin
            $display("idp_header_checksum_verify_top verification clean");
        end else begin
            $display("idp_header_checksum_verify_top verification failed");
        end
        $finish;
    end

endmodule
